FILE: hw/rtl/hclb_pkg.sv
// ----------------------------------------------------------------------------
// Huffman code length builder package
// Shared widths, payload types and helpers of the code length builder.
// ----------------------------------------------------------------------------
package hclb_pkg;

    localparam int NUM_SYMBOLS = 16;
    localparam int FREQ_BITS   = 16;
    localparam int NODE_COUNT  = 2 * NUM_SYMBOLS - 1;
    localparam int NODE_W      = $clog2(NODE_COUNT);
    localparam int SYM_IDX_W   = $clog2(NUM_SYMBOLS);
    localparam int LEAF_CNT_W  = $clog2(NUM_SYMBOLS + 1);
    localparam int WEIGHT_W    = FREQ_BITS + $clog2(NUM_SYMBOLS);
    localparam int LEN_W       = 4;
    localparam logic [LEN_W-1:0] MAX_LEN = 4'd15;

    typedef struct packed {
        logic [3:0]  symbol;
        logic [15:0] frequency;
        logic        last_item;
    } t_in_item;

    typedef struct packed {
        logic [3:0]       out_symbol;
        logic [LEN_W-1:0] code_length;
        logic             last_result;
    } t_out_item;

    // One classified transaction on its way from the front to the back.
    typedef struct packed {
        logic [3:0]           symbol;
        logic [FREQ_BITS-1:0] weight;
        logic                 last_item;
        logic                 keep;
    } t_q_entry;

    function automatic logic [FREQ_BITS-1:0] mask_freq(input logic [15:0] f);
        logic [31:0] wide;
        wide = 32'(f);
        return wide[FREQ_BITS-1:0];
    endfunction

endpackage

FILE: hw/rtl/hclb_front.sv
// ----------------------------------------------------------------------------
// Code length builder front
// Accepts input transactions and marks those that overflow the current set.
// ----------------------------------------------------------------------------
module hclb_front import hclb_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  t_in_item i_in_data,
    output logic     o_in_stall,
    input  logic     i_q_full,
    output logic     o_q_push,
    output t_q_entry o_q_data
);

    logic [LEAF_CNT_W-1:0] r_set_cnt;
    logic                  keep;

    assign keep       = (r_set_cnt < LEAF_CNT_W'(NUM_SYMBOLS));
    assign o_in_stall = i_q_full;
    assign o_q_push   = i_in_valid && !i_q_full;
    assign o_q_data   = '{symbol:    i_in_data.symbol,
                          weight:    mask_freq(i_in_data.frequency),
                          last_item: i_in_data.last_item,
                          keep:      keep};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set_cnt <= '0;
        end else if (o_q_push) begin
            if (i_in_data.last_item) begin
                r_set_cnt <= '0;
            end else if (keep) begin
                r_set_cnt <= r_set_cnt + 1'b1;
            end
        end
    end

endmodule

FILE: hw/rtl/hclb_queue.sv
// ----------------------------------------------------------------------------
// Code length builder queue
// Two-entry queue between the front and the back.
// ----------------------------------------------------------------------------
module hclb_queue import hclb_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_q_entry i_data,
    output logic     o_full,
    input  logic     i_pop,
    output logic     o_valid,
    output t_q_entry o_data
);

    t_q_entry   r_mem [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_mem[r_wr] <= i_data;
                r_wr        <= ~r_wr;
            end
            if (i_pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

endmodule

FILE: hw/rtl/hclb_back.sv
// ----------------------------------------------------------------------------
// Code length builder back
// Stores leaves, merges the tree, propagates depths and emits lengths.
// ----------------------------------------------------------------------------
module hclb_back import hclb_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_q_valid,
    input  t_q_entry  i_q_data,
    output logic      o_q_pop,
    output logic      o_out_valid,
    output t_out_item o_out_data,
    input  logic      i_out_stall
);

    typedef enum logic [2:0] {
        ST_LOAD, ST_SCAN, ST_MERGE_A, ST_MERGE_B, ST_DEPTH, ST_EMIT
    } t_state;

    t_state                r_state;
    logic [LEAF_CNT_W-1:0] r_leaf_total;
    logic [NODE_W-1:0]     r_count;
    logic [NODE_W-1:0]     r_idx;
    logic                  r_b1_ok;
    logic [NODE_W-1:0]     r_b1_idx;
    logic [WEIGHT_W-1:0]   r_b1_w;
    logic                  r_b2_ok;
    logic [NODE_W-1:0]     r_b2_idx;
    logic [WEIGHT_W-1:0]   r_b2_w;
    logic [NODE_COUNT-1:0] r_active;
    logic [WEIGHT_W-1:0]   r_weight [NODE_COUNT];
    logic [NODE_W-1:0]     r_parent [NODE_COUNT];
    logic [LEN_W-1:0]      r_depth  [NODE_COUNT];
    logic [3:0]            r_sym    [NUM_SYMBOLS];
    logic                  r_out_valid;
    t_out_item             r_out_data;

    logic [LEAF_CNT_W-1:0] new_total;
    logic [WEIGHT_W-1:0]   scan_w;
    logic [LEN_W-1:0]      par_depth;
    logic                  out_free;
    logic                  emit_last;

    assign o_q_pop     = (r_state == ST_LOAD) && i_q_valid;
    assign new_total   = i_q_data.keep ? r_leaf_total + 1'b1 : r_leaf_total;
    assign scan_w      = r_weight[r_idx];
    assign par_depth   = r_depth[r_parent[r_idx]];
    assign out_free    = !r_out_valid || !i_out_stall;
    assign emit_last   = (LEAF_CNT_W'(r_idx) + 1'b1 == r_leaf_total);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_LOAD;
            r_leaf_total <= '0;
            r_active     <= '0;
            r_out_valid  <= 1'b0;
            r_idx        <= '0;
            r_count      <= '0;
            r_b1_ok      <= 1'b0;
            r_b2_ok      <= 1'b0;
        end else begin
            if (out_free && r_state != ST_EMIT) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_LOAD: begin
                    if (i_q_valid) begin
                        if (i_q_data.keep) begin
                            r_sym[r_leaf_total[SYM_IDX_W-1:0]]    <= i_q_data.symbol;
                            r_weight[NODE_W'(r_leaf_total)]       <= WEIGHT_W'(i_q_data.weight);
                            r_active[NODE_W'(r_leaf_total)]       <= 1'b1;
                        end
                        r_leaf_total <= new_total;
                        if (i_q_data.last_item) begin
                            r_count <= NODE_W'(new_total);
                            r_idx   <= '0;
                            r_b1_ok <= 1'b0;
                            r_b2_ok <= 1'b0;
                            r_state <= ST_SCAN;
                        end
                    end
                end
                ST_SCAN: begin
                    // Strict compares in ascending order keep the lower index on ties.
                    if (r_active[r_idx]) begin
                        if (!r_b1_ok || scan_w < r_b1_w) begin
                            r_b2_ok  <= r_b1_ok;
                            r_b2_idx <= r_b1_idx;
                            r_b2_w   <= r_b1_w;
                            r_b1_ok  <= 1'b1;
                            r_b1_idx <= r_idx;
                            r_b1_w   <= scan_w;
                        end else if (!r_b2_ok || scan_w < r_b2_w) begin
                            r_b2_ok  <= 1'b1;
                            r_b2_idx <= r_idx;
                            r_b2_w   <= scan_w;
                        end
                    end
                    if (r_idx == r_count - 1'b1) begin
                        r_state <= ST_MERGE_A;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                ST_MERGE_A: begin
                    if (!r_b2_ok) begin
                        r_depth[r_count - 1'b1] <= '0;
                        if (r_count == NODE_W'(1)) begin
                            r_idx   <= '0;
                            r_state <= ST_EMIT;
                        end else begin
                            r_idx   <= r_count - NODE_W'(2);
                            r_state <= ST_DEPTH;
                        end
                    end else begin
                        r_weight[r_count]  <= r_b1_w + r_b2_w;
                        r_parent[r_b1_idx] <= r_count;
                        r_active[r_b1_idx] <= 1'b0;
                        r_active[r_b2_idx] <= 1'b0;
                        r_active[r_count]  <= 1'b1;
                        r_state            <= ST_MERGE_B;
                    end
                end
                ST_MERGE_B: begin
                    r_parent[r_b2_idx] <= r_count;
                    r_count            <= r_count + 1'b1;
                    r_idx              <= '0;
                    r_b1_ok            <= 1'b0;
                    r_b2_ok            <= 1'b0;
                    r_state            <= ST_SCAN;
                end
                ST_DEPTH: begin
                    r_depth[r_idx] <= (par_depth == MAX_LEN) ? MAX_LEN : par_depth + 1'b1;
                    if (r_idx == '0) begin
                        r_state <= ST_EMIT;
                    end else begin
                        r_idx <= r_idx - 1'b1;
                    end
                end
                ST_EMIT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= '{out_symbol:  r_sym[r_idx[SYM_IDX_W-1:0]],
                                         code_length: r_depth[r_idx],
                                         last_result: emit_last};
                        if (emit_last) begin
                            r_active     <= '0;
                            r_leaf_total <= '0;
                            r_state      <= ST_LOAD;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end
                end
                default: begin
                    r_state <= ST_LOAD;
                end
            endcase
        end
    end

endmodule

FILE: hw/rtl/huffman_code_length_builder.sv
// ----------------------------------------------------------------------------
// Huffman code length builder
// Collects (symbol, frequency) leaves and reports the Huffman code length of
// each leaf in load order once the last leaf of a set has arrived.
// ----------------------------------------------------------------------------
//  Channel  Direction  Payload     Handshake
//  in       input      t_in_item   i_in_valid / o_in_stall
//  out      output     t_out_item  o_out_valid / i_out_stall
//
// A leaf transaction passes the front combinationally, is written into the
// queue and is stored by the back as it pops it; a two-entry queue lets the
// front keep accepting while the back is busy. For a set of N leaves the back
// runs, per merge, a minimum scan over every node in the node store and its
// two merge states, then one last scan, a root step, a depth pass over the
// nodes below the root and an emit pass over the leaves.
// Reset is synchronous and active low; no clearing pass is needed.
// A stall on the output holds the result register and the back waits in its
// emit state; a stall on the input is raised only when the queue is full.
// ----------------------------------------------------------------------------
module huffman_code_length_builder import hclb_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  t_in_item  i_in_data,
    output logic      o_in_stall,
    output logic      o_out_valid,
    output t_out_item o_out_data,
    input  logic      i_out_stall
);

    // Transactions classified by the front, with overflow leaves marked.
    logic     q_full;
    logic     q_push;
    t_q_entry q_wdata;
    logic     q_valid;
    logic     q_pop;
    t_q_entry q_rdata;

    hclb_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .o_in_stall (o_in_stall),
        .i_q_full   (q_full),
        .o_q_push   (q_push),
        .o_q_data   (q_wdata)
    );

    hclb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_rdata)
    );

    // The back owns the tree stores and the output register.
    hclb_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_data    (q_rdata),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

endmodule

FILE: tb/sv/tb_huffman_code_length_builder.sv
// ----------------------------------------------------------------------------
// Huffman code length builder testbench
// Drives sets of (symbol, frequency) leaves with bursty valid and a stalling
// receiver, predicts each set's code lengths and checks every result.
// ----------------------------------------------------------------------------

// Holds the predicted code lengths and compares each result against them.
class code_length_board;
    hclb_pkg::t_out_item pending[$];
    bit [3:0]  sym_store[hclb_pkg::NUM_SYMBOLS];
    bit [19:0] weight_store[hclb_pkg::NODE_COUNT];
    int        leaf_count;
    int        mismatches;
    int        checked;
    int        sets_done;
    int        lone_sets;
    int        overflow_drops;

    function new();
        leaf_count = 0;
        mismatches = 0;
        checked = 0;
        sets_done = 0;
        lone_sets = 0;
        overflow_drops = 0;
    endfunction

    // Returns the lowest-weight active node, lower index on ties, or -1.
    function int lowest(input bit act[hclb_pkg::NODE_COUNT], input int count);
        int best;
        best = -1;
        for (int i = 0; i < count; i++)
            if (act[i] && (best < 0 || weight_store[i] < weight_store[best]))
                best = i;
        return best;
    endfunction

    // Notes one accepted input transaction and, on the last one, predicts lengths.
    function void note_input(input hclb_pkg::t_in_item it);
        bit act[hclb_pkg::NODE_COUNT];
        int parent[hclb_pkg::NODE_COUNT];
        int depth[hclb_pkg::NODE_COUNT];
        int count, a, b, p, d;
        hclb_pkg::t_out_item r;
        if (leaf_count < hclb_pkg::NUM_SYMBOLS) begin
            sym_store[leaf_count] = it.symbol;
            weight_store[leaf_count] = 20'(it.frequency);
            leaf_count++;
        end else begin
            overflow_drops++;
        end
        if (!it.last_item)
            return;
        for (int i = 0; i < hclb_pkg::NODE_COUNT; i++) begin
            act[i] = (i < leaf_count);
            parent[i] = 0;
            depth[i] = 0;
        end
        count = leaf_count;
        forever begin
            a = lowest(act, count);
            if (a < 0) break;
            act[a] = 0;
            b = lowest(act, count);
            if (b < 0) break;
            act[b] = 0;
            if (count >= hclb_pkg::NODE_COUNT) break;
            weight_store[count] = weight_store[a] + weight_store[b];
            parent[a] = count;
            parent[b] = count;
            act[count] = 1;
            count++;
        end
        // Depths flow down from the root; a deep leaf saturates at the maximum length.
        for (int i = count - 2; i >= 0; i--) begin
            p = parent[i];
            if (p < hclb_pkg::NODE_COUNT && p > i) begin
                d = depth[p] + 1;
                depth[i] = (d > 15) ? 15 : d;
            end else begin
                depth[i] = 0;
            end
        end
        for (int i = 0; i < leaf_count; i++) begin
            r.out_symbol = sym_store[i];
            r.code_length = 4'(depth[i]);
            r.last_result = (i + 1 == leaf_count);
            pending.push_back(r);
        end
        if (leaf_count == 1) lone_sets++;
        sets_done++;
        leaf_count = 0;
    endfunction

    // Checks one accepted result transaction against the oldest expectation.
    function void check_result(input hclb_pkg::t_out_item got);
        hclb_pkg::t_out_item want;
        checked++;
        if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result: sym=%0d len=%0d last=%0b",
                         got.out_symbol, got.code_length, got.last_result);
            return;
        end
        want = pending.pop_front();
        if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: exp sym=%0d len=%0d last=%0b, got sym=%0d len=%0d last=%0b",
                         want.out_symbol, want.code_length, want.last_result,
                         got.out_symbol, got.code_length, got.last_result);
        end
    endfunction
endclass

module tb_huffman_code_length_builder;
    import hclb_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // With stalls on the output lengthening the emit time, the limit stays far
    // above a correct run.
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 100;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    t_in_item  i_in_data = '0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_item o_out_data;
    logic      i_out_stall = 1'b0;

    code_length_board board;
    int cycle_count = 0;
    int leaves_sent = 0;
    bit recv_stall_on = 1'b1;

    huffman_code_length_builder uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

    always #5 i_clk = ~i_clk;

    // The cycle counter guards against a hung block.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // The receiver stalls at random while stalling is enabled; a transaction is taken at
    // an edge where valid is high and stall is low, sampled before the update.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            board.check_result(o_out_data);
        if (recv_stall_on)
            i_out_stall <= ($urandom_range(0, 3) == 0);
        else
            i_out_stall <= 1'b0;
    end

    // Sends one leaf, holding it until the block accepts the transaction. The
    // task raises valid itself at an edge and keeps it high across items.
    task automatic send_leaf(input logic [3:0] sym, input logic [15:0] freq,
                             input logic last);
        i_in_valid <= 1'b1;
        i_in_data <= '{symbol: sym, frequency: freq, last_item: last};
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        board.note_input(i_in_data);
        leaves_sent++;
    endtask

    // A gap of random length with valid low, drawn only between bursts.
    task automatic idle_gap();
        int n;
        n = $urandom_range(1, 6);
        i_in_valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // Random set: mostly small sizes, sometimes full, occasionally overflowing.
    task automatic send_random_set();
        int size, pick, burst;
        logic [15:0] f;
        pick = $urandom_range(0, 9);
        if (pick < 6) size = $urandom_range(2, 6);
        else if (pick < 8) size = $urandom_range(7, 16);
        else if (pick < 9) size = 1;
        else size = $urandom_range(17, 19);
        burst = $urandom_range(1, 5);
        for (int i = 0; i < size; i++) begin
            case ($urandom_range(0, 3))
                0: f = 16'($urandom_range(0, 3));
                1: f = 16'($urandom);
                2: f = 16'(1 << $urandom_range(0, 15));
                default: f = 16'($urandom_range(0, 255));
            endcase
            send_leaf(4'($urandom), f, i == size - 1);
            if (--burst == 0) begin
                idle_gap();
                burst = $urandom_range(1, 5);
            end
        end
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (board.pending.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        board = new();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed sets: lone symbol, extremes, ties, zero weights, repeats.
        send_leaf(4'd15, 16'hFFFF, 1'b1);
        send_leaf(4'd0, 16'd0, 1'b0);
        send_leaf(4'd15, 16'hFFFF, 1'b1);
        send_leaf(4'd3, 16'd5, 1'b0);
        send_leaf(4'd3, 16'd5, 1'b0);
        send_leaf(4'd3, 16'd5, 1'b1);
        send_leaf(4'd9, 16'd0, 1'b0);
        send_leaf(4'd10, 16'd0, 1'b1);
        // Fibonacci-like weights give the deepest tree; 16 of them reach length 15.
        begin
            int fa, fb, t;
            fa = 1; fb = 1;
            for (int i = 0; i < 16; i++) begin
                send_leaf(4'(i), 16'(fa), i == 15);
                t = fa + fb; fa = fb; fb = (t > 65535) ? 65535 : t;
            end
        end
        // Hold off until every result is back, then overflow a full set.
        wait_drained();
        recv_stall_on = 1'b0;
        for (int i = 0; i < 18; i++)
            send_leaf(4'(i), 16'hAAAA ^ 16'(i * 4369), i == 17);
        wait_drained();
        recv_stall_on = 1'b1;

        while (leaves_sent < 110)
            send_random_set();
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d leaves in %0d sets, %0d lone sets, %0d dropped overflow leaves",
                 leaves_sent, board.sets_done, board.lone_sets, board.overflow_drops);
        $display("checked %0d results, %0d mismatches", board.checked, board.mismatches);
        if (board.mismatches == 0 && board.pending.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
